// ----- hw/rtl/nfbl_pkg.sv -----
`timescale 1ns / 1ps

package nfbl_pkg;

    // list size default and queue depth between front and back
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 4;
    localparam int DIST_W     = 16;
    localparam int CALL_W     = 64;
    localparam int TYPE_W     = 32;
    localparam int ALT_W      = 17;
    localparam int BEAR_W     = 12;
    localparam int SPEED_W    = 14;
    localparam int TRACK_W    = 12;
    localparam int AGE_W      = 16;
    localparam int MOTION_W   = ALT_W + BEAR_W + SPEED_W + TRACK_W;
    localparam int SLOT_W     = 4;
    localparam int KEPT_W     = 5;
    localparam int OFFERED_W  = 16;

    // stream widths; tdata is padded to whole bytes
    localparam int S_TDATA_W  = 192;
    localparam int S_TUSER_W  = CMD_W;
    localparam int M_TDATA_W  = 208;
    localparam int M_TUSER_W  = 1;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_READ,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FULL_CHECK,
        ST_WALK,
        ST_PLACE,
        ST_RESPOND
    } state_t;

    // one held record; motion is {track, speed, bearing, altitude}
    typedef struct packed {
        logic [AGE_W-1:0]    age;
        logic [MOTION_W-1:0] motion;
        logic [TYPE_W-1:0]   type_code;
        logic [CALL_W-1:0]   callsign;
        logic [DIST_W-1:0]   distance;
    } record_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] read_index;
        record_t            rec;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic                 accepted;
        logic [SLOT_W-1:0]    slot;
        logic [KEPT_W-1:0]    kept_count;
        logic [OFFERED_W-1:0] offered_total;
        record_t              rec;
    } result_t;

endpackage

// ----- hw/rtl/nearest_first_bounded_list.sv -----
`timescale 1ns / 1ps
// channel  | direction | tdata                                         | tuser
// s_*      | in        | index, distance, callsign, type, motion, age  | cmd
// m_*      | out       | slot, kept, offered, entry fields             | accepted
//
// clear, no-op and read go from idle straight to the response state; an insert adds
// a full check when the list is full, then a walk shifting each farther entry down the
// memory, then the new record's write; a dropped record skips to the response.
// the walk is set by the single write and single read port of the entry memory.
// reset empties the list and the offered total; entry contents are not cleared.
// a two-deep queue takes input transfers while the back end works or waits on m_tready.

module nearest_first_bounded_list
#(
    parameter int MAX_ENTRIES = nfbl_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // read_index, distance, callsign, type_code, altitude, bearing,
    // ground_speed, track_angle, position_age, zero pad
    input  logic [nfbl_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [nfbl_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot, kept_count, offered_total, out_distance, out_callsign,
    // out_type_code, out_altitude, out_bearing, out_ground_speed,
    // out_track_angle, out_position_age
    output logic [nfbl_pkg::M_TDATA_W-1:0] m_tdata,
    // accepted
    output logic [nfbl_pkg::M_TUSER_W-1:0] m_tuser
);
    import nfbl_pkg::*;

    queue_status_t q_status;
    queue_item_t   push_item;
    queue_item_t   pop_item;
    logic          q_push;
    logic          q_pop;
    result_t       result;

    nfbl_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    nfbl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    nfbl_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    // pack the result transfer
    assign m_tdata = {result.rec.age, result.rec.motion, result.rec.type_code,
                      result.rec.callsign, result.rec.distance, result.offered_total,
                      result.kept_count, result.slot};
    assign m_tuser = result.accepted;

    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
    else $error("queue push while full");

    // queue never read when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

    // a kept record was counted in the offered total
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[24:9] != '0))
    else $error("accepted insert with zero offered total");

    // a dropped or non-insert result reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[3:0] == '0))
    else $error("slot set on a result that kept nothing");

endmodule

// ----- hw/rtl/nfbl_front.sv -----
`timescale 1ns / 1ps

module nfbl_front
(
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [nfbl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [nfbl_pkg::S_TUSER_W-1:0]   s_tuser,
    input  nfbl_pkg::queue_status_t          q_status,
    output logic                             q_push,
    output nfbl_pkg::queue_item_t            q_item
);
    import nfbl_pkg::*;

    // take a transfer whenever the queue has room
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && !q_status.full;

    // classify the command and unpack the record; motion fields sit together in tdata
    always_comb
    begin
        unique case (s_tuser)
            CMD_CLEAR:  q_item.op = OP_CLEAR;
            CMD_INSERT: q_item.op = OP_INSERT;
            CMD_READ:   q_item.op = OP_READ;
            CMD_NOP:    q_item.op = OP_NOP;
        endcase
        q_item.read_index    = s_tdata[3:0];
        q_item.rec.distance  = s_tdata[19:4];
        q_item.rec.callsign  = s_tdata[83:20];
        q_item.rec.type_code = s_tdata[115:84];
        q_item.rec.motion    = s_tdata[170:116];
        q_item.rec.age       = s_tdata[186:171];
    end

endmodule

// ----- hw/rtl/nfbl_queue.sv -----
`timescale 1ns / 1ps

module nfbl_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  nfbl_pkg::queue_item_t   push_item,
    input  logic                    pop,
    output nfbl_pkg::queue_item_t   pop_item,
    output nfbl_pkg::queue_status_t status
);
    import nfbl_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    queue_item_t         slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]       level_reg, level_next;

    // status and head item
    assign status.full  = (level_reg == LW'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign pop_item     = slots_reg[rd_ptr_reg];

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/nfbl_back.sv -----
`timescale 1ns / 1ps

module nfbl_back
#(
    parameter int MAX_ENTRIES = nfbl_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  nfbl_pkg::queue_status_t q_status,
    input  nfbl_pkg::queue_item_t   q_item,
    output logic                    q_pop,
    input  logic                    out_ready,
    output logic                    out_valid,
    output nfbl_pkg::result_t       out_result
);
    import nfbl_pkg::*;

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int KW   = CW + KEPT_W;
    localparam int SW   = AW + SLOT_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

    // entry store
    record_t            mem [MAX_ENTRIES];
    record_t            rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    record_t            wr_data;

    state_t             state_reg, state_next;
    queue_item_t        item_reg, item_next;
    logic [AW-1:0]      at_reg, at_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [OFFERED_W-1:0] offered_reg, offered_next;
    logic               acc_reg, acc_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               out_free;
    logic [CMPW-1:0]    ridx_ext;
    logic [CMPW-1:0]    count_ext;
    logic [KW-1:0]      kept_ext;
    logic [SW-1:0]      slot_ext;

    assign out_free   = !out_valid_reg || out_ready;
    assign ridx_ext   = CMPW'(q_item.read_index);
    assign count_ext  = CMPW'(count_reg);
    assign kept_ext   = KW'(count_reg);
    assign slot_ext   = SW'(at_reg);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // sequencer: decode, full check, shift walk, placement, response
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        at_next        = at_reg;
        count_next     = count_reg;
        offered_next   = offered_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = at_reg - AW'(1);
        wr_en          = 1'b0;
        wr_addr        = at_reg;
        wr_data        = item_reg.rec;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    acc_next   = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_RESPOND;
                    unique case (q_item.op)
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            offered_next = '0;
                        end
                        OP_READ:
                        begin
                            hit_next = (ridx_ext < count_ext);
                            rd_en    = (ridx_ext < count_ext);
                            rd_addr  = ridx_ext[AW-1:0];
                        end
                        OP_INSERT:
                        begin
                            if (offered_reg != '1)
                            begin
                                offered_next = offered_reg + OFFERED_W'(1);
                            end
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                // full: compare against the farthest entry first
                                at_next    = LAST;
                                rd_en      = 1'b1;
                                rd_addr    = LAST;
                                state_next = ST_FULL_CHECK;
                            end
                            else
                            begin
                                at_next    = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    state_next = ST_PLACE;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(count_reg - CW'(1));
                                    state_next = ST_WALK;
                                end
                            end
                        end
                        OP_NOP:
                        begin
                        end
                    endcase
                end
            end

            ST_FULL_CHECK:
            begin
                if (item_reg.rec.distance >= rd_data_reg.distance)
                begin
                    state_next = ST_RESPOND;
                end
                else if (at_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = at_reg - AW'(1);
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                // read data holds the entry just above the hole
                if (rd_data_reg.distance > item_reg.rec.distance)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                    at_next = at_reg - AW'(1);
                    if (at_reg == AW'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = at_reg - AW'(2);
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    acc_next   = 1'b1;
                    state_next = ST_RESPOND;
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                acc_next   = 1'b1;
                state_next = ST_RESPOND;
            end

            ST_RESPOND:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.accepted      = acc_reg;
                    out_next.slot          = acc_reg ? slot_ext[SLOT_W-1:0] : '0;
                    out_next.kept_count    = kept_ext[KEPT_W-1:0];
                    out_next.offered_total = offered_reg;
                    out_next.rec           = hit_reg ? rd_data_reg : '0;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            offered_reg   <= '0;
            acc_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            offered_reg   <= offered_next;
            acc_reg       <= acc_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        at_reg   <= at_next;
        out_reg  <= out_next;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ----- test/nearest_first_bounded_list_test.sv -----
`timescale 1ns / 1ps

module nearest_first_bounded_list_test;

    import nfbl_pkg::*;

    localparam int LIST_SIZE   = MAX_ENTRIES_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = LIST_SIZE + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 300;
    localparam int RANDOM_OPS  = 1000;
    localparam int FAR_N       = 40;
    localparam int REPORT_MAX  = 10;

    // record content patterns for the directed table
    localparam int REC_LOW  = 0;
    localparam int REC_HIGH = 1;
    localparam int REC_RAND = 2;

    typedef struct {
        op_t          op;
        logic [3:0]   idx;
        record_t      rec;
        bit           typed;
        result_t      want;
    } dir_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // shadow copy of the list
    record_t     held_rec [LIST_SIZE];
    int          held_count = 0;
    logic [15:0] offered_sum = '0;

    result_t     predicted_results[$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    bit          fast_phase = 1'b0;
    bit          calm = 1'b0;
    bit          hold_done = 1'b0;

    nearest_first_bounded_list #(
        .MAX_ENTRIES(LIST_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // next state of the list and the result of one command
    function automatic result_t nearest_list_step(op_t op, logic [3:0] idx, record_t rec);
        result_t r;
        int      pos;
        bit      keep;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                held_count  = 0;
                offered_sum = '0;
            end
            OP_INSERT:
            begin
                if (offered_sum != 16'hFFFF)
                    offered_sum = offered_sum + 16'd1;
                keep = 1'b1;
                pos  = held_count;
                if (held_count >= LIST_SIZE)
                begin
                    if (rec.distance >= held_rec[LIST_SIZE-1].distance)
                        keep = 1'b0;
                    else
                        pos = LIST_SIZE - 1;
                end
                else
                begin
                    held_count++;
                end
                if (keep)
                begin
                    // shift farther entries down, ties stay ahead
                    while (pos > 0 && held_rec[pos-1].distance > rec.distance)
                    begin
                        held_rec[pos] = held_rec[pos-1];
                        pos--;
                    end
                    held_rec[pos] = rec;
                    r.accepted = 1'b1;
                    r.slot     = pos[SLOT_W-1:0];
                end
            end
            OP_READ:
            begin
                if (int'(idx) < held_count)
                    r.rec = held_rec[idx];
            end
            default:
            begin
            end
        endcase
        r.kept_count    = held_count[KEPT_W-1:0];
        r.offered_total = offered_sum;
        return r;
    endfunction

    function automatic record_t make_record(logic [15:0] rec_distance, int kind);
        record_t r;
        r.distance = rec_distance;
        case (kind)
            REC_LOW:
            begin
                r.callsign  = '0;
                r.type_code = '0;
                r.motion    = {12'd0, 14'd0, 12'd0, 17'h10000};
                r.age       = '0;
            end
            REC_HIGH:
            begin
                r.callsign  = '1;
                r.type_code = '1;
                r.motion    = {12'd3599, 14'd16383, 12'd3599, 17'h0FFFF};
                r.age       = '1;
            end
            default:
            begin
                r.callsign  = {$urandom(), $urandom()};
                r.type_code = $urandom();
                r.motion    = {12'($urandom_range(0, 3599)), 14'($urandom_range(0, 16383)),
                               12'($urandom_range(0, 3599)), 17'($urandom())};
                r.age       = 16'($urandom());
            end
        endcase
        return r;
    endfunction

    function automatic result_t plain_result(bit acc, int slot, int kept, int offered);
        result_t r;
        r               = '0;
        r.accepted      = acc;
        r.slot          = SLOT_W'(slot);
        r.kept_count    = KEPT_W'(kept);
        r.offered_total = OFFERED_W'(offered);
        return r;
    endfunction

    function automatic dir_row_t row(op_t op, int idx, record_t rec, bit typed, result_t want);
        dir_row_t d;
        d.op    = op;
        d.idx   = 4'(idx);
        d.rec   = rec;
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    function automatic logic [15:0] pick_distance();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'd0;
        else if (k == 1)
            return 16'hFFFF;
        else if (k < 6)
            return 16'(100 * $urandom_range(0, 7));
        else
            return 16'($urandom());
    endfunction

    // offer one transfer and log its expected result once taken
    task automatic put_transfer(op_t op, logic [3:0] idx, record_t rec, bit typed,
                                result_t want);
        int      gap;
        result_t pred;
        gap = (fast_phase || calm) ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({rec, idx});
        do @(posedge clk); while (!s_tready);
        pred = nearest_list_step(op, idx, rec);
        predicted_results.push_back(typed ? want : pred);
    endtask

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("error: result %0d field %s expected %h got %h",
                         results_seen, what, want, got);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin : result_drain
        int stall;
        forever
        begin
            stall = (fast_phase || calm) ? 0 : $urandom_range(0, 4);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall     = stall + HOLD_CYCLES;
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            {got.rec, got.offered_total, got.kept_count, got.slot} = m_tdata;
            got.accepted = m_tuser[0];
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("error: result %0d arrived with none expected", results_seen);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("slot", want.slot, got.slot);
                check_field("kept_count", want.kept_count, got.kept_count);
                check_field("offered_total", want.offered_total, got.offered_total);
                check_field("distance", want.rec.distance, got.rec.distance);
                check_field("callsign", want.rec.callsign, got.rec.callsign);
                check_field("type_code", want.rec.type_code, got.rec.type_code);
                check_field("altitude", want.rec.motion[ALT_W-1:0],
                            got.rec.motion[ALT_W-1:0]);
                check_field("bearing", want.rec.motion[ALT_W +: BEAR_W],
                            got.rec.motion[ALT_W +: BEAR_W]);
                check_field("ground_speed", want.rec.motion[ALT_W+BEAR_W +: SPEED_W],
                            got.rec.motion[ALT_W+BEAR_W +: SPEED_W]);
                check_field("track_angle", want.rec.motion[ALT_W+BEAR_W+SPEED_W +: TRACK_W],
                            got.rec.motion[ALT_W+BEAR_W+SPEED_W +: TRACK_W]);
                check_field("position_age", want.rec.age, got.rec.age);
            end
            results_seen++;
        end
    end

    // end the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    rows[$];
        result_t     none;
        op_t         op;
        logic [3:0]  idx;
        int          pick;
        none = '0;

        // directed table: extremes, ties, reads past the end, clear
        rows.push_back(row(OP_READ,   0, make_record(16'd0, REC_LOW), 1, plain_result(0, 0, 0, 0)));
        rows.push_back(row(OP_NOP,    0, make_record(16'd0, REC_HIGH), 1, plain_result(0, 0, 0, 0)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'd500, REC_HIGH), 1,
                           plain_result(1, 0, 1, 1)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'd0, REC_LOW), 1,
                           plain_result(1, 0, 2, 2)));
        rows.push_back(row(OP_INSERT, 15, make_record(16'hFFFF, REC_HIGH), 1,
                           plain_result(1, 2, 3, 3)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'd500, REC_RAND), 1,
                           plain_result(1, 2, 4, 4)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'hFFFF, REC_LOW), 1,
                           plain_result(1, 4, 5, 5)));
        for (int i = 0; i < 5; i++)
            rows.push_back(row(OP_READ, i, make_record(16'hFFFF, REC_HIGH), 0, none));
        rows.push_back(row(OP_READ,   5, make_record(16'd0, REC_LOW), 1, plain_result(0, 0, 5, 5)));
        rows.push_back(row(OP_READ,  15, make_record(16'd0, REC_LOW), 1, plain_result(0, 0, 5, 5)));
        rows.push_back(row(OP_NOP,   15, make_record(16'd7, REC_RAND), 1, plain_result(0, 0, 5, 5)));
        rows.push_back(row(OP_CLEAR, 15, make_record(16'd7, REC_HIGH), 1, plain_result(0, 0, 0, 0)));
        rows.push_back(row(OP_READ,   0, make_record(16'd0, REC_LOW), 1, plain_result(0, 0, 0, 0)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'hFFFF, REC_HIGH), 1,
                           plain_result(1, 0, 1, 1)));
        rows.push_back(row(OP_INSERT, 0, make_record(16'd1, REC_RAND), 1,
                           plain_result(1, 0, 2, 2)));
        rows.push_back(row(OP_READ,   0, make_record(16'd0, REC_LOW), 0, none));
        rows.push_back(row(OP_READ,   1, make_record(16'd0, REC_LOW), 0, none));
        rows.push_back(row(OP_CLEAR,  0, make_record(16'd0, REC_LOW), 1, plain_result(0, 0, 0, 0)));

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            put_transfer(rows[i].op, rows[i].idx, rows[i].rec, rows[i].typed, rows[i].want);

        // random mix, mostly inserts and reads so the list fills and evicts
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 6)
                op = OP_NOP;
            else if (pick < 60)
                op = OP_INSERT;
            else
                op = OP_READ;
            if (held_count > 0 && $urandom_range(0, 3) != 0)
                idx = 4'($urandom_range(0, held_count - 1));
            else
                idx = 4'($urandom_range(0, 15));
            put_transfer(op, idx, make_record(pick_distance(), REC_RAND), 0, none);
        end
        calm = 1'b0;

        // far records offered back to back against a full list of near records
        fast_phase = 1'b1;
        put_transfer(OP_CLEAR, 4'd0, make_record(16'd0, REC_RAND), 0, none);
        for (int n = 0; n < LIST_SIZE; n++)
            put_transfer(OP_INSERT, 4'd0, make_record(16'($urandom_range(0, 200)), REC_RAND),
                         0, none);
        for (int n = 0; n < FAR_N; n++)
            put_transfer(OP_INSERT, 4'($urandom()),
                         make_record(16'($urandom_range(200, 65535)), REC_RAND), 0, none);
        fast_phase = 1'b0;
        for (int n = 0; n < LIST_SIZE; n++)
            put_transfer(OP_READ, 4'(n), make_record(16'd0, REC_RAND), 0, none);
        for (int n = 0; n < 4; n++)
            put_transfer(OP_INSERT, 4'd0, make_record(16'($urandom_range(0, 100)), REC_RAND),
                         0, none);
        put_transfer(OP_READ, 4'($urandom()), make_record(16'd0, REC_RAND), 0, none);
        put_transfer(OP_CLEAR, 4'd0, make_record(16'd0, REC_RAND), 0, none);
        s_tvalid <= 1'b0;

        // drain and let the back end settle
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/nfbl_pkg.sv
hw/rtl/nfbl_front.sv
hw/rtl/nfbl_queue.sv
hw/rtl/nfbl_back.sv
hw/rtl/nearest_first_bounded_list.sv
test/nearest_first_bounded_list_test.sv
